@@ hdl/rgbh_pkg.sv @@
`default_nettype none

package rgbh_pkg;

    localparam int PIX_W      = 8;
    localparam int BIN_W      = 9;
    localparam int GRID_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // pixel_b, pixel_g, pixel_r, bin_index packed from the lowest bit up
    localparam int IN_FIELDS_W = 3 * PIX_W + BIN_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_G  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_R  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_B     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_G     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_R     = 3'd6;

    localparam logic [GRID_W-1:0] GRID_RESET = 4'd3;

    typedef struct packed {
        logic clr;    // zero one store entry of the clearing pass
        logic load;   // capture the input beat
        logic level;  // register channel levels and recolor values
        logic bin;    // register bin address and target hit
        logic rd;     // read the store
        logic wr;     // write back the count and load the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;  // clearing pass is at its last entry
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/rgb_grid_bin_histogram_recolor.sv @@
// Uniform RGB grid quantizer with a per-bin histogram and target-bin recolor.
//
// Input stream (s_axis): tuser carries func (0 process pixel, 1 read and clear
// one bin); tdata carries pixel_b, pixel_g, pixel_r and bin_index.
// Output stream (m_axis): one result beat per input beat, in order: bin_id,
// recolored pixel, recolored flag and bin count.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (grid size,
// target color, new color) at the clock edge; write only while idle.
//
// Each item passes through capture, channel levels, bin address, counter
// store read, then write-back with the result loaded into the output register.
// The store read-modify-write keeps one item in flight: a new item is taken
// only after the previous one is written back. The next beat is accepted
// while a result waits; a stalled receiver holds the result and blocks only
// the write-back of the following item.
// Reset: registers return to their defaults and a clearing pass zeros all
// MAX_GRID^3 counter store entries (512 at the default) before s_axis_tready
// rises. Counters saturate at all ones.
`default_nettype none

module rgb_grid_bin_histogram_recolor
    import rgbh_pkg::*;
#(
    parameter int MAX_GRID    = 8,
    parameter int COUNT_WIDTH = 32,
    localparam int OUT_FIELDS_W = BIN_W + 3 * PIX_W + 1 + COUNT_WIDTH,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_b, pixel_g, pixel_r, bin_index
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  wire                   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // bin_id, out_b, out_g, out_r, recolored, bin_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic [BIN_W-1:0]       w_bin_id;
    logic [PIX_W-1:0]       w_out_b, w_out_g, w_out_r;
    logic                   w_recolored;
    logic [COUNT_WIDTH-1:0] w_bin_count;

    rgbh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    rgbh_dp #(
        .MAX_GRID    (MAX_GRID),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser),
        .i_pixel_b   (s_axis_tdata[0 +: PIX_W]),
        .i_pixel_g   (s_axis_tdata[PIX_W +: PIX_W]),
        .i_pixel_r   (s_axis_tdata[2*PIX_W +: PIX_W]),
        .i_bin_index (s_axis_tdata[3*PIX_W +: BIN_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_bin_id    (w_bin_id),
        .o_out_b     (w_out_b),
        .o_out_g     (w_out_g),
        .o_out_r     (w_out_r),
        .o_recolored (w_recolored),
        .o_bin_count (w_bin_count)
    );

    assign m_axis_tdata = OUT_DATA_W'({w_bin_count, w_recolored, w_out_r, w_out_g,
                                       w_out_b, w_bin_id});

endmodule

`default_nettype wire

@@ hdl/rgbh_ctrl.sv @@
`default_nettype none

module rgbh_ctrl
    import rgbh_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEVEL,
        S_BIN,
        S_READ,
        S_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LEVEL;
                end
            end
            S_LEVEL: begin
                o_cmd.level = 1'b1;
                n_state     = S_BIN;
            end
            S_BIN: begin
                o_cmd.bin = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                // hold until the output register is free, then commit once
                if (i_sts.out_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while an item is in flight");

    a_read_before_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_WRITE))
        else $error("store read not followed by write-back stage");

endmodule

`default_nettype wire

@@ hdl/rgbh_dp.sv @@
`default_nettype none

module rgbh_dp
    import rgbh_pkg::*;
#(
    parameter int MAX_GRID    = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                    i_func,
    input  wire  [PIX_W-1:0]       i_pixel_b,
    input  wire  [PIX_W-1:0]       i_pixel_g,
    input  wire  [PIX_W-1:0]       i_pixel_r,
    input  wire  [BIN_W-1:0]       i_bin_index,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [BIN_W-1:0]       o_bin_id,
    output logic [PIX_W-1:0]       o_out_b,
    output logic [PIX_W-1:0]       o_out_g,
    output logic [PIX_W-1:0]       o_out_r,
    output logic                   o_recolored,
    output logic [COUNT_WIDTH-1:0] o_bin_count
);

    localparam int NUM_BINS = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW       = $clog2(NUM_BINS);
    localparam int LVL_W    = $clog2(MAX_GRID);
    localparam int NSQ_W    = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int PROD_W   = PIX_W + GRID_W;
    localparam int SC_W     = PIX_W + 2;

    // configuration
    logic [GRID_W-1:0] r_grid;
    logic [PIX_W-1:0]  r_tgt_b, r_tgt_g, r_tgt_r;
    logic [PIX_W-1:0]  r_new_b, r_new_g, r_new_r;

    // captured beat
    logic              r_func;
    logic [PIX_W-1:0]  r_pb, r_pg, r_pr;
    logic [BIN_W-1:0]  r_idx;

    // level stage
    logic [GRID_W-1:0] r_n;
    logic [NSQ_W-1:0]  r_nsq;
    logic [LVL_W-1:0]  r_lvl_b, r_lvl_g, r_lvl_r;
    logic [LVL_W-1:0]  r_tlvl_b, r_tlvl_g, r_tlvl_r;
    logic [PIX_W-1:0]  r_sc_b, r_sc_g, r_sc_r;

    // bin stage
    logic [BIN_W-1:0]  r_bin;
    logic              r_hit;
    logic              r_in_range;

    // store
    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [AW-1:0]          r_clr_addr;

    // output register
    logic                   r_out_valid;
    logic [BIN_W-1:0]       r_out_bin;
    logic [PIX_W-1:0]       r_out_b, r_out_g, r_out_r;
    logic                   r_out_hit;
    logic [COUNT_WIDTH-1:0] r_out_cnt;

    logic [GRID_W-1:0]      w_eff_n;
    logic [BIN_W-1:0]       w_pix_bin;
    logic [BIN_W-1:0]       w_tgt_bin;
    logic [COUNT_WIDTH-1:0] w_cnt_inc;
    logic [COUNT_WIDTH-1:0] w_wdata;
    logic [COUNT_WIDTH-1:0] w_cnt_out;
    logic                   w_out_free;

    function automatic logic [LVL_W-1:0] f_level(input logic [PIX_W-1:0]  c,
                                                 input logic [GRID_W-1:0] n);
        logic [PROD_W-1:0] p;
        p = PROD_W'(c) * PROD_W'(n);
        return p[PIX_W +: LVL_W];
    endfunction

    function automatic logic [PIX_W-1:0] f_shift_clamp(input logic [PIX_W-1:0] c,
                                                       input logic [PIX_W-1:0] to,
                                                       input logic [PIX_W-1:0] from);
        logic [SC_W-1:0] v;
        logic [PIX_W-1:0] res;
        v = SC_W'(c) + SC_W'(to) - SC_W'(from);
        if (v[SC_W-1]) begin
            res = '0;
        end else if (v[PIX_W]) begin
            res = '1;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        if (r_grid == '0) begin
            w_eff_n = GRID_W'(1);
        end else if (r_grid > GRID_W'(MAX_GRID)) begin
            w_eff_n = GRID_W'(MAX_GRID);
        end else begin
            w_eff_n = r_grid;
        end
    end

    assign w_pix_bin = BIN_W'(r_lvl_r) + BIN_W'(r_lvl_g) * BIN_W'(r_n)
                     + BIN_W'(r_lvl_b) * BIN_W'(r_nsq);
    assign w_tgt_bin = BIN_W'(r_tlvl_r) + BIN_W'(r_tlvl_g) * BIN_W'(r_n)
                     + BIN_W'(r_tlvl_b) * BIN_W'(r_nsq);

    // saturate at all ones
    assign w_cnt_inc = (&r_rdata) ? r_rdata : r_rdata + COUNT_WIDTH'(1);
    assign w_wdata   = r_func ? '0 : w_cnt_inc;
    assign w_cnt_out = !r_in_range ? '0 : (r_func ? r_rdata : w_cnt_inc);

    assign w_out_free     = !r_out_valid || i_out_ready;
    assign o_sts.out_free = w_out_free;
    assign o_sts.clr_last = (r_clr_addr == AW'(NUM_BINS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= GRID_RESET;
            r_tgt_b <= '0;
            r_tgt_g <= '0;
            r_tgt_r <= '0;
            r_new_b <= '0;
            r_new_g <= '0;
            r_new_r <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_SIZE: r_grid  <= i_cfg_data[GRID_W-1:0];
                CFG_TARGET_B:  r_tgt_b <= i_cfg_data;
                CFG_TARGET_G:  r_tgt_g <= i_cfg_data;
                CFG_TARGET_R:  r_tgt_r <= i_cfg_data;
                CFG_NEW_B:     r_new_b <= i_cfg_data;
                CFG_NEW_G:     r_new_g <= i_cfg_data;
                CFG_NEW_R:     r_new_r <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pb   <= i_pixel_b;
            r_pg   <= i_pixel_g;
            r_pr   <= i_pixel_r;
            r_idx  <= i_bin_index;
        end
        if (i_cmd.level) begin
            r_n      <= w_eff_n;
            r_nsq    <= NSQ_W'(w_eff_n) * NSQ_W'(w_eff_n);
            r_lvl_b  <= f_level(r_pb, w_eff_n);
            r_lvl_g  <= f_level(r_pg, w_eff_n);
            r_lvl_r  <= f_level(r_pr, w_eff_n);
            r_tlvl_b <= f_level(r_tgt_b, w_eff_n);
            r_tlvl_g <= f_level(r_tgt_g, w_eff_n);
            r_tlvl_r <= f_level(r_tgt_r, w_eff_n);
            r_sc_b   <= f_shift_clamp(r_pb, r_new_b, r_tgt_b);
            r_sc_g   <= f_shift_clamp(r_pg, r_new_g, r_tgt_g);
            r_sc_r   <= f_shift_clamp(r_pr, r_new_r, r_tgt_r);
        end
        if (i_cmd.bin) begin
            r_bin      <= r_func ? r_idx : w_pix_bin;
            r_hit      <= !r_func && (w_pix_bin == w_tgt_bin);
            r_in_range <= r_func ? ((BIN_W + 1)'(r_idx) < (BIN_W + 1)'(NUM_BINS))
                                 : ((BIN_W + 1)'(w_pix_bin) < (BIN_W + 1)'(NUM_BINS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr && r_in_range) begin
            r_mem[r_bin[AW-1:0]] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_bin[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_out_bin <= r_bin;
            r_out_b   <= r_func ? '0 : (r_hit ? r_sc_b : r_pb);
            r_out_g   <= r_func ? '0 : (r_hit ? r_sc_g : r_pg);
            r_out_r   <= r_func ? '0 : (r_hit ? r_sc_r : r_pr);
            r_out_hit <= r_hit;
            r_out_cnt <= w_cnt_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_id    = r_out_bin;
    assign o_out_b     = r_out_b;
    assign o_out_g     = r_out_g;
    assign o_out_r     = r_out_r;
    assign o_recolored = r_out_hit;
    assign o_bin_count = r_out_cnt;

    a_commit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> w_out_free)
        else $error("result committed over an untaken result");

    a_pixel_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && !r_func && r_in_range) |-> (w_wdata != '0))
        else $error("pixel update wrote a zero count");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |=> r_out_valid)
        else $error("committed result not presented");

    a_no_clear_during_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !(i_cmd.wr || i_cmd.rd || i_cmd.load))
        else $error("store access overlaps the clearing pass");

endmodule

`default_nettype wire

@@ dv/tb_rgb_grid_bin_histogram_recolor.sv @@
`timescale 1ns / 100ps

module tb_rgb_grid_bin_histogram_recolor;
    import rgbh_pkg::*;

    localparam int MAX_GRID    = 8;
    localparam int COUNT_W     = 32;
    localparam int N_BINS      = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int OUT_DATA_W  = ((BIN_W + 3 * PIX_W + 1 + COUNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 800000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 185;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_id;
        logic [PIX_W-1:0]   b;
        logic [PIX_W-1:0]   g;
        logic [PIX_W-1:0]   r;
        logic               hit;
        logic [COUNT_W-1:0] count;
    } t_bin_result;

    class hist_scoreboard;
        logic [COUNT_W-1:0] bin_counts [N_BINS];
        logic [GRID_W-1:0]  grid_reg;
        logic [PIX_W-1:0]   tgt_b, tgt_g, tgt_r, rep_b, rep_g, rep_r;
        t_bin_result        result_q [$];
        int unsigned        errors, pixels, reads, hits, checked;

        function new();
            foreach (bin_counts[k]) bin_counts[k] = '0;
            grid_reg = GRID_RESET;
            tgt_b = '0; tgt_g = '0; tgt_r = '0;
            rep_b = '0; rep_g = '0; rep_r = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_SIZE: grid_reg = data[GRID_W-1:0];
                CFG_TARGET_B:  tgt_b = data;
                CFG_TARGET_G:  tgt_g = data;
                CFG_TARGET_R:  tgt_r = data;
                CFG_NEW_B:     rep_b = data;
                CFG_NEW_G:     rep_g = data;
                CFG_NEW_R:     rep_r = data;
                default: ;
            endcase
        endfunction

        // out-of-range grid sizes fold to 1 or MAX_GRID
        function int grid_levels();
            if (grid_reg == 0) return 1;
            if (grid_reg > MAX_GRID) return MAX_GRID;
            return int'(grid_reg);
        endfunction

        function logic [BIN_W-1:0] color_bin(logic [PIX_W-1:0] b, g, r);
            int n;
            n = grid_levels();
            return BIN_W'(((int'(r) * n) >> 8) + ((int'(g) * n) >> 8) * n
                          + ((int'(b) * n) >> 8) * n * n);
        endfunction

        function logic [PIX_W-1:0] shift_clamp(logic [PIX_W-1:0] c, to, from);
            int v;
            v = int'(c) + int'(to) - int'(from);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return PIX_W'(v);
        endfunction

        function void note_input(logic func, logic [PIX_W-1:0] b, g, r,
                                 logic [BIN_W-1:0] idx);
            t_bin_result want;
            logic [BIN_W-1:0] pbin;
            want = '0;
            if (func) begin
                // read and clear one counter
                want.bin_id = idx;
                want.count = bin_counts[idx];
                bin_counts[idx] = '0;
                reads++;
            end else begin
                pbin = color_bin(b, g, r);
                if (bin_counts[pbin] != '1) bin_counts[pbin] = bin_counts[pbin] + 1'b1;
                want.bin_id = pbin;
                want.count = bin_counts[pbin];
                want.b = b;
                want.g = g;
                want.r = r;
                if (pbin == color_bin(tgt_b, tgt_g, tgt_r)) begin
                    want.hit = 1'b1;
                    want.b = shift_clamp(b, rep_b, tgt_b);
                    want.g = shift_clamp(g, rep_g, tgt_g);
                    want.r = shift_clamp(r, rep_r, tgt_r);
                    hits++;
                end
                pixels++;
            end
            result_q = {result_q, want};
        endfunction

        task report(string field, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
            if (errors < 30)
                $display("ERROR: result %0d field %s got %0d want %0d",
                         checked, field, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            t_bin_result got, want;
            got.bin_id = d[8:0];
            got.b      = d[16:9];
            got.g      = d[24:17];
            got.r      = d[32:25];
            got.hit    = d[33];
            got.count  = d[65:34];
            if (result_q.size() == 0) begin
                report("unexpected_beat", COUNT_W'(got.bin_id), '0);
            end else begin
                want = result_q.pop_front();
                if (got.bin_id !== want.bin_id)
                    report("bin_id", COUNT_W'(got.bin_id), COUNT_W'(want.bin_id));
                if (got.b !== want.b) report("out_b", COUNT_W'(got.b), COUNT_W'(want.b));
                if (got.g !== want.g) report("out_g", COUNT_W'(got.g), COUNT_W'(want.g));
                if (got.r !== want.r) report("out_r", COUNT_W'(got.r), COUNT_W'(want.r));
                if (got.hit !== want.hit)
                    report("recolored", COUNT_W'(got.hit), COUNT_W'(want.hit));
                if (got.count !== want.count) report("bin_count", got.count, want.count);
            end
            checked++;
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // pixel_b, pixel_g, pixel_r, bin_index
    logic                  s_axis_tuser = 1'b0; // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // bin_id, out_b, out_g, out_r, recolored, bin_count

    hist_scoreboard sb;
    bit             gaps_on = 1'b1;
    int unsigned    stall_left = 0;
    int unsigned    cycles = 0;
    int unsigned    settings = 0;

    rgb_grid_bin_histogram_recolor #(
        .MAX_GRID    (MAX_GRID),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.result_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, long ones now and then
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                              s_axis_tdata[23:16], s_axis_tdata[32:24]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    task automatic send_item(input logic func, input logic [PIX_W-1:0] b, g, r,
                             input logic [BIN_W-1:0] idx);
        int  gap;
        bit  hold;
        gap = (gaps_on && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
        hold = ($urandom_range(0, 299) == 0);
        if (gap > 0 || hold) begin
            s_axis_tvalid <= 1'b0;
            // hold off until the pipeline has emptied
            if (hold) do @(posedge i_clk); while (sb.result_q.size() != 0);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= IN_DATA_W'({idx, r, g, b});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pixel(input logic [PIX_W-1:0] b, g, r);
        send_item(1'b0, b, g, r, BIN_W'($urandom_range(0, N_BINS - 1)));
    endtask

    task automatic read_bin(input logic [BIN_W-1:0] idx);
        send_item(1'b1, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), idx);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (sb.result_q.size() != 0);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] grid_byte, tb, tg, tr,
                                nb, ng, nr);
        logic [CFG_DATA_W-1:0] vals [7];
        logic [CFG_IDX_W-1:0]  regs [7];
        int k;
        vals = '{grid_byte, tb, tg, tr, nb, ng, nr};
        regs = '{CFG_GRID_SIZE, CFG_TARGET_B, CFG_TARGET_G, CFG_TARGET_R,
                 CFG_NEW_B, CFG_NEW_G, CFG_NEW_R};
        s_axis_tvalid <= 1'b0;
        drain();
        for (k = 0; k < 7; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= vals[k];
            sb.write_reg(regs[k], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [PIX_W-1:0] near(logic [PIX_W-1:0] c);
        int v;
        v = int'(c) + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    function automatic logic [PIX_W-1:0] any_channel();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom);
    endfunction

    task automatic random_item();
        int n;
        int sel;
        n = sb.grid_levels();
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            read_bin(BIN_W'($urandom_range(0, n * n * n - 1)));
        end else if (sel < 16) begin
            read_bin(BIN_W'($urandom_range(0, N_BINS - 1)));
        end else if (sel < 50) begin
            pixel(near(sb.tgt_b), near(sb.tgt_g), near(sb.tgt_r));
        end else begin
            pixel(any_channel(), any_channel(), any_channel());
        end
    endtask

    initial begin
        int p, k;
        logic [3:0] grid_pick [N_PHASES];
        logic [PIX_W-1:0] tv, nv;

        sb = new();
        grid_pick = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd4, 4'd7, 4'd5};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: grid of 3, target and new both black
        pixel(8'd0, 8'd0, 8'd0);
        pixel(8'd255, 8'd255, 8'd255);
        pixel(8'd85, 8'd85, 8'd85);
        pixel(8'd86, 8'd170, 8'd171);
        read_bin(9'd0);
        read_bin(9'd0);
        read_bin(9'd511);
        read_bin(9'd26);

        // finest grid, offsets that clamp at both ends
        program_regs(8'h08, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
        pixel(8'd255, 8'd0, 8'd128);
        pixel(8'd224, 8'd31, 8'd130);
        pixel(8'd0, 8'd255, 8'd0);
        pixel(8'd223, 8'd0, 8'd128);
        read_bin(9'd452);
        read_bin(9'd511);

        // grid of zero folds to one bin: every pixel recolors
        program_regs(8'h00, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        pixel(8'd0, 8'd0, 8'd0);
        pixel(8'd200, 8'd13, 8'd77);
        read_bin(9'd0);

        // grid above the maximum folds to the maximum
        program_regs(8'hFF, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        pixel(8'd255, 8'd255, 8'd255);
        pixel(8'd224, 8'd240, 8'd250);
        pixel(8'd10, 8'd20, 8'd30);
        read_bin(9'd511);

        for (p = 0; p < N_PHASES; p++) begin
            if (p < 2) begin
                tv = (p == 0) ? 8'd0 : 8'd255;
                nv = ~tv;
                program_regs({4'($urandom), grid_pick[p]}, tv, tv, tv, nv, nv, nv);
            end else begin
                program_regs({4'($urandom), grid_pick[p]}, PIX_W'($urandom),
                             PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                             PIX_W'($urandom), PIX_W'($urandom));
            end
            gaps_on = (p != 3);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 2) gaps_on = !gaps_on;
                random_item();
            end
        end

        s_axis_tvalid <= 1'b0;
        drain();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d pixel beats (%0d recolored) and %0d bin reads, %0d results checked",
                 sb.pixels, sb.hits, sb.reads, sb.checked);
        $display("over %0d register settings including folded grid sizes and clamped offsets",
                 settings);
        if (sb.errors == 0 && sb.result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (sb.result_q.size() != 0)
                $display("ERROR: %0d results never arrived", sb.result_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
